// ===== rtl/sdrg_pkg.sv =====
package sdrg_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int CC_W        = 3;
    localparam int GAIN_W      = 17;
    localparam int STEP_W      = 19;
    localparam int CFG_W       = 19;
    localparam int IDX_W       = 2;

    // s2 is in half-sample units, gain is Q16
    localparam int SCALE_SHIFT = 17;

    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_REPEAT_DEF      = 8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN          = 2'd1;
    localparam logic [IDX_W-1:0] REG_PHASE_STEP    = 2'd2;

    localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = 3'd2;
    localparam logic [CC_W-1:0]   CHANNEL_MAX       = 3'd5;
    localparam logic [GAIN_W-1:0] GAIN_UNITY        = 17'h10000;
    localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 19'h10000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] front_left;
        logic signed [SAMPLE_BITS-1:0] front_right;
        logic signed [SAMPLE_BITS-1:0] center;
        logic signed [SAMPLE_BITS-1:0] rear_left;
        logic signed [SAMPLE_BITS-1:0] rear_right;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          last_of_run;
    } t_frame_out;

    typedef struct packed {
        logic capture;
        logic mul;
        logic sat;
        logic emit;
        logic last;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic below_one;
        logic next_below_one;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/sdrg_ctrl.sv =====
module sdrg_ctrl #(
    parameter int MAX_REPEAT = sdrg_pkg::MAX_REPEAT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output sdrg_pkg::t_dp_cmd o_cmd,
    input  sdrg_pkg::t_dp_sts i_sts
);
    import sdrg_pkg::*;

    localparam int CNT_W = $clog2(MAX_REPEAT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REPEAT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_REPEAT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SAT  = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_more;

    // another output is due while phase is below one and the cap is not reached
    assign w_more     = i_sts.below_one && (r_count != CNT_MAX);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_count   = '0;
                n_state   = S_RUN;
            end
            S_RUN: begin
                if (w_more) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = !i_sts.next_below_one || (r_count == CNT_LAST);
                        n_count    = r_count + 1'b1;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    a_emit_under_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_count < CNT_MAX))
        else $error("output emitted beyond repeat cap");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (!o_cmd.emit && o_cmd.finish))
        else $error("output after last_of_run");

endmodule

// ===== rtl/sdrg_dp.sv =====
module sdrg_dp #(
    parameter int PHASE_FRAC_BITS = sdrg_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sdrg_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [sdrg_pkg::CFG_W-1:0]  i_cfg_data,
    input  sdrg_pkg::t_frame_in         i_in_data,
    input  sdrg_pkg::t_dp_cmd           i_cmd,
    output sdrg_pkg::t_dp_sts           o_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sdrg_pkg::t_frame_out        o_out_data
);
    import sdrg_pkg::*;

    localparam int MIX_W = SAMPLE_BITS + 3;
    localparam int PRD_W = MIX_W + GAIN_W + 1;
    localparam int PH_W  = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
    localparam logic [PH_W-1:0] PH_ONE = {{(PH_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
    localparam logic signed [PRD_W-1:0] S_MAX = PRD_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PRD_W-1:0] RND   = PRD_W'((1 << SCALE_SHIFT) - 1);

    function automatic logic [SAMPLE_BITS-1:0] scale_sat(input logic signed [PRD_W-1:0] p);
        logic signed [PRD_W-1:0] b;
        logic signed [PRD_W-1:0] q;
        // truncate toward zero, then clamp symmetric
        b = p + (p[PRD_W-1] ? RND : '0);
        q = b >>> SCALE_SHIFT;
        if (q > S_MAX)
            q = S_MAX;
        else if (q < -S_MAX)
            q = -S_MAX;
        return q[SAMPLE_BITS-1:0];
    endfunction

    logic [CC_W-1:0]          r_chan_cnt;
    logic [GAIN_W-1:0]        r_gain;
    logic [STEP_W-1:0]        r_step;
    logic [PH_W-1:0]          r_phase;
    logic signed [MIX_W-1:0]  r_l2, r_r2;
    logic signed [PRD_W-1:0]  r_lp, r_rp;
    logic [SAMPLE_BITS-1:0]   r_lo, r_ro;
    logic                     r_out_valid;
    t_frame_out               r_out_data;

    logic [CC_W-1:0]          w_nch;
    logic signed [GAIN_W:0]   w_gain;
    logic signed [MIX_W-1:0]  w_c0, w_c1, w_c2, w_c3, w_c4;
    logic signed [MIX_W-1:0]  w_l2, w_r2;
    logic [PH_W-1:0]          w_ph_sum;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CHANNEL_COUNT_RST;
            r_gain     <= GAIN_UNITY;
            r_step     <= PHASE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data[CC_W-1:0];
                REG_GAIN:          r_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_PHASE_STEP:    r_step     <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_nch  = (r_chan_cnt > CHANNEL_MAX) ? CHANNEL_MAX : r_chan_cnt;
    assign w_gain = $signed({1'b0, ((r_gain > GAIN_UNITY) ? GAIN_UNITY : r_gain)});

    assign w_c0 = MIX_W'(i_in_data.front_left);
    assign w_c1 = MIX_W'(i_in_data.front_right);
    assign w_c2 = MIX_W'(i_in_data.center);
    assign w_c3 = MIX_W'(i_in_data.rear_left);
    assign w_c4 = MIX_W'(i_in_data.rear_right);

    // downmix in half-sample units
    always_comb begin
        w_l2 = '0;
        w_r2 = '0;
        if (w_nch == 3'd1) begin
            w_l2 = w_c0 <<< 1;
            w_r2 = w_c0 <<< 1;
        end else if (w_nch >= 3'd2) begin
            w_l2 = (w_c0 <<< 1) + ((w_nch >= 3'd3) ? w_c2 : '0)
                 + ((w_nch >= 3'd4) ? w_c3 : '0);
            w_r2 = (w_c1 <<< 1) + ((w_nch >= 3'd3) ? w_c2 : '0)
                 + ((w_nch >= 3'd5) ? w_c4 : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_l2 <= w_l2;
            r_r2 <= w_r2;
        end
        if (i_cmd.mul) begin
            r_lp <= r_l2 * w_gain;
            r_rp <= r_r2 * w_gain;
        end
        if (i_cmd.sat) begin
            r_lo <= scale_sat(r_lp);
            r_ro <= scale_sat(r_rp);
        end
    end

    // phase accumulator
    assign w_ph_sum = r_phase + PH_W'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.emit) begin
            r_phase <= w_ph_sum;
        end else if (i_cmd.finish) begin
            r_phase <= (r_phase < PH_ONE) ? '0 : (r_phase - PH_ONE);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.left_sample  <= r_lo;
            r_out_data.right_sample <= r_ro;
            r_out_data.last_of_run  <= i_cmd.last;
        end
    end

    assign o_sts.below_one      = (r_phase < PH_ONE);
    assign o_sts.next_below_one = (w_ph_sum < PH_ONE);
    assign o_sts.out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("pending output overwritten");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.left_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                      && r_out_data.right_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("output outside saturation range");

endmodule

// ===== rtl/stereo_downmix_resample_gain_unit.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------
// in        | input     | i_in_valid / o_in_stall | i_in_data   (t_frame_in)
// out       | output    | o_out_valid / i_out_stall | o_out_data (t_frame_out)
// cfg       | input     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// a source frame goes through capture and mix, multiply, and scale and clamp,
// then the run with one emit per output transfer, and a closing step for the phase
// update, giving n outputs (n from 0 to MAX_REPEAT)
// the input is stalled while the controller is not idle; the single
// output register lets the next frame enter while the last result waits
// a stall on the output holds the run at the pending output
// synchronous active-low reset restores the register defaults and clears phase
module stereo_downmix_resample_gain_unit #(
    parameter int PHASE_FRAC_BITS = sdrg_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAX_REPEAT      = sdrg_pkg::MAX_REPEAT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [sdrg_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [sdrg_pkg::CFG_W-1:0] i_cfg_data,
    // source frames
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sdrg_pkg::t_frame_in        i_in_data,
    // stereo outputs
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sdrg_pkg::t_frame_out       o_out_data
);
    import sdrg_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: frame steps and repeat count
    sdrg_ctrl #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath: config, mix, gain, clamp, phase accumulator, output register
    sdrg_dp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
